// ===== rtl/hmbs_pkg.sv =====
package hmbs_pkg;

  // map geometry limits
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // field widths
  localparam int SIZE_W   = 9;
  localparam int COORD_W  = 8;
  localparam int FRAC_W   = 8;
  localparam int QUERY_W  = COORD_W + FRAC_W;
  localparam int INDEX_W  = 16;
  localparam int SAMPLE_W = 8;
  localparam int HEIGHT_W = 15;
  localparam int WEIGHT_W = FRAC_W + 1;
  localparam int ROW_W    = COORD_W + SIZE_W;

  // blend and scaling widths
  localparam int COL_W    = 16;
  localparam int BLEND_W  = 24;
  localparam int SCALE    = 100;
  localparam int SCALE_W  = 7;
  localparam int SCALED_W = 23;
  localparam int RECIP_W  = 24;
  localparam int RECIP_SH = 31;

  // reciprocal of 255, exact for every scaled value below 2^23
  localparam logic [RECIP_W-1:0] RECIP_255 = 24'd8421505;

  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 15'd25600;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;

  // input modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] i0;
    logic [COORD_W-1:0] i1;
    logic [FRAC_W-1:0]  f;
  } coord_t;

  // four corner samples and weights handed to the blend pipeline
  typedef struct packed {
    logic                valid;
    logic [SAMPLE_W-1:0] s00;
    logic [SAMPLE_W-1:0] s10;
    logic [SAMPLE_W-1:0] s01;
    logic [SAMPLE_W-1:0] s11;
    logic [FRAC_W-1:0]   fx;
    logic [FRAC_W-1:0]   fz;
  } taps_t;

  // effective map size: zero acts as one, clipped to the maximum
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r, input int maxv);
    logic [SIZE_W-1:0] v;
    v = r;
    if (r == '0) begin
      v = SIZE_W'(1);
    end else if (int'(r) > maxv) begin
      v = SIZE_W'(maxv);
    end
    return v;
  endfunction

  // split an 8.8 coordinate, saturating past the last index
  function automatic coord_t split(input logic [QUERY_W-1:0] q, input logic [SIZE_W-1:0] last);
    coord_t c;
    logic [SIZE_W-1:0] nxt;
    c.i0 = q[QUERY_W-1:FRAC_W];
    c.f  = q[FRAC_W-1:0];
    if ({1'b0, c.i0} > last) begin
      c.i0 = last[COORD_W-1:0];
      c.f  = '0;
    end
    nxt = {1'b0, c.i0} + SIZE_W'(1);
    c.i1 = (nxt > last) ? last[COORD_W-1:0] : nxt[COORD_W-1:0];
    return c;
  endfunction

endpackage

// ===== rtl/hmbs_if.sv =====
interface hmbs_in_if;
  import hmbs_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [INDEX_W-1:0]  sample_index;
  logic [SAMPLE_W-1:0] sample_value;
  logic [QUERY_W-1:0]  query_x;
  logic [QUERY_W-1:0]  query_z;
  modport source (output valid, mode, sample_index, sample_value, query_x, query_z,
                  input ready);
  modport sink (input valid, mode, sample_index, sample_value, query_x, query_z,
                output ready);
  modport monitor (input valid, ready, mode, sample_index, sample_value, query_x, query_z);
endinterface

interface hmbs_out_if;
  import hmbs_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
  modport monitor (input valid, ready, height);
endinterface

interface hmbs_cfg_if;
  import hmbs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface

// ===== rtl/hmbs_ram.sv =====
module hmbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read, read data holds when idle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== rtl/hmbs_blend.sv =====
module hmbs_blend
  import hmbs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  taps_t             taps,
  output logic              ready,
  hmbs_out_if.source        result
);

  // column stage
  logic               d_valid;
  logic [COL_W-1:0]   d_col0;
  logic [COL_W-1:0]   d_col1;
  logic [FRAC_W-1:0]  d_fx;
  // row stage
  logic               e_valid;
  logic [BLEND_W-1:0] e_blend;
  // scaled by 100/256
  logic               f_valid;
  logic [SCALED_W-1:0] f_scaled;
  // output word
  logic               g_valid;
  logic [HEIGHT_W-1:0] g_height;

  logic d_free, e_free, f_free, g_free;

  logic [WEIGHT_W-1:0] wz0, wz1, wx0, wx1;
  logic [ROW_W-1:0]    col0_sum, col1_sum;
  logic [BLEND_W:0]    blend_sum;
  logic [SCALED_W+SCALE_W+FRAC_W-1:0] scaled_full;
  logic [SCALED_W+RECIP_W-1:0]        quot_full;

  // stall chain from the output word back to the input
  assign g_free = !g_valid || result.ready;
  assign f_free = !f_valid || g_free;
  assign e_free = !e_valid || f_free;
  assign d_free = !d_valid || e_free;
  assign ready  = d_free;

  // weights
  assign wz1 = {1'b0, taps.fz};
  assign wz0 = WEIGHT_W'(1 << FRAC_W) - wz1;
  assign wx1 = {1'b0, d_fx};
  assign wx0 = WEIGHT_W'(1 << FRAC_W) - wx1;

  // blend down each column
  assign col0_sum = ROW_W'(taps.s00 * wz0) + ROW_W'(taps.s01 * wz1);
  assign col1_sum = ROW_W'(taps.s10 * wz0) + ROW_W'(taps.s11 * wz1);

  // blend across the two columns
  assign blend_sum = (BLEND_W+1)'(d_col0 * wx0) + (BLEND_W+1)'(d_col1 * wx1);

  // scale by 100 and drop eight bits
  assign scaled_full = (SCALED_W+SCALE_W+FRAC_W)'(e_blend * SCALE_W'(SCALE));

  // divide by 255 through the reciprocal
  assign quot_full = (SCALED_W+RECIP_W)'(f_scaled * RECIP_255);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else begin
      if (d_free) d_valid <= taps.valid;
      if (e_free) e_valid <= d_valid;
      if (f_free) f_valid <= e_valid;
      if (g_free) g_valid <= f_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (d_free) begin
      d_col0 <= col0_sum[COL_W-1:0];
      d_col1 <= col1_sum[COL_W-1:0];
      d_fx   <= taps.fx;
    end
    if (e_free) begin
      e_blend <= blend_sum[BLEND_W-1:0];
    end
    if (f_free) begin
      f_scaled <= scaled_full[SCALED_W+FRAC_W-1:FRAC_W];
    end
    if (g_free) begin
      g_height <= quot_full[RECIP_SH+HEIGHT_W-1:RECIP_SH];
    end
  end

  assign result.valid  = g_valid;
  assign result.height = g_height;

endmodule

// ===== rtl/heightmap_bilinear_sampler_unit.sv =====
// Height-map bilinear sampler. A load word (mode 0) writes one 8-bit sample at
// sample_index and returns nothing; a query word (mode 1) takes 8.8 column and
// row coordinates and returns the bilinear blend of the four neighbouring
// samples, scaled to 0..100 world units with 8 fraction bits. One word is
// accepted per clock while the pipeline is not stalled; a query passes through
// seven register stages, of which the first is loaded at acceptance: row
// offset, corner address, memory read and four arithmetic stages (column
// blend, row blend, scaling by 100, division by 255). The store
// is held as four identical copies written together by every load, so each
// corner of a query has its own read port. A load is visible to any query
// accepted after it. Samples are undefined until loaded; there is no clearing
// pass after reset. map_width and map_height may only be written while idle.
module heightmap_bilinear_sampler_unit
  import hmbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  hmbs_in_if.sink    item,
  hmbs_out_if.source result,
  hmbs_cfg_if.sink   cfg
);

  localparam int CORNERS = 4;

  logic [SIZE_W-1:0] map_width;
  logic [SIZE_W-1:0] map_height;

  logic [SIZE_W-1:0] w_eff, h_eff;
  coord_t            cx, cz;
  logic              accept;

  // address stage
  logic               a_valid;
  logic               a_load;
  logic [ADDR_W-1:0]  a_index;
  logic [SAMPLE_W-1:0] a_value;
  logic [COORD_W-1:0] a_x0, a_x1;
  logic [FRAC_W-1:0]  a_fx, a_fz;
  logic [ROW_W-1:0]   a_r0, a_r1;

  // memory access stage
  logic               b_valid;
  logic               b_load;
  logic [ADDR_W-1:0]  b_index;
  logic [SAMPLE_W-1:0] b_value;
  logic [ADDR_W-1:0]  b_addr [CORNERS];
  logic [FRAC_W-1:0]  b_fx, b_fz;

  // read data stage
  logic               c_valid;
  logic [FRAC_W-1:0]  c_fx, c_fz;

  logic a_free, b_free, c_free, blend_ready;
  logic ram_en;
  logic [ADDR_W-1:0]   ram_addr  [CORNERS];
  logic [SAMPLE_W-1:0] ram_rdata [CORNERS];
  logic [ROW_W-1:0]    addr_sum  [CORNERS];
  taps_t taps;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= SIZE_W'(MAX_WIDTH);
      map_height <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAP_WIDTH:  map_width  <= cfg.data;
        REG_MAP_HEIGHT: map_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective size and coordinate split
  assign w_eff = eff_size(map_width, MAX_WIDTH);
  assign h_eff = eff_size(map_height, MAX_HEIGHT);
  assign cx    = split(item.query_x, w_eff - SIZE_W'(1));
  assign cz    = split(item.query_z, h_eff - SIZE_W'(1));

  // stall chain
  assign c_free     = !c_valid || blend_ready;
  assign b_free     = !b_valid || b_load || c_free;
  assign a_free     = !a_valid || b_free;
  assign item.ready = a_free;
  assign accept     = item.valid && a_free;

  // corner addresses: x0z0, x1z0, x0z1, x1z1
  assign addr_sum[0] = a_r0 + ROW_W'(a_x0);
  assign addr_sum[1] = a_r0 + ROW_W'(a_x1);
  assign addr_sum[2] = a_r1 + ROW_W'(a_x0);
  assign addr_sum[3] = a_r1 + ROW_W'(a_x1);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_free) a_valid <= accept;
      if (b_free) b_valid <= a_valid;
      if (c_free) c_valid <= b_valid && !b_load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_free) begin
      a_load  <= (item.mode == MODE_LOAD);
      a_index <= ADDR_W'(item.sample_index);
      a_value <= item.sample_value;
      a_x0    <= cx.i0;
      a_x1    <= cx.i1;
      a_fx    <= cx.f;
      a_fz    <= cz.f;
      a_r0    <= ROW_W'(cz.i0 * w_eff);
      a_r1    <= ROW_W'(cz.i1 * w_eff);
    end
    if (b_free) begin
      // an index past the store drops the load
      b_load  <= a_load && (32'(a_index) < STORE_DEPTH);
      b_index <= a_index;
      b_value <= a_value;
      b_fx    <= a_fx;
      b_fz    <= a_fz;
      for (int k = 0; k < CORNERS; k++) begin
        b_addr[k] <= addr_sum[k][ADDR_W-1:0];
      end
    end
    if (c_free) begin
      c_fx <= b_fx;
      c_fz <= b_fz;
    end
  end

  // four copies of the store, one per corner
  assign ram_en = b_valid && (b_load || c_free);

  for (genvar k = 0; k < CORNERS; k++) begin : g_store
    assign ram_addr[k] = b_load ? b_index : b_addr[k];
    hmbs_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(STORE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .en   (ram_en),
      .we   (b_load),
      .addr (ram_addr[k]),
      .wdata(b_value),
      .rdata(ram_rdata[k])
    );
  end

  // blend pipeline
  assign taps.valid = c_valid;
  assign taps.s00   = ram_rdata[0];
  assign taps.s10   = ram_rdata[1];
  assign taps.s01   = ram_rdata[2];
  assign taps.s11   = ram_rdata[3];
  assign taps.fx    = c_fx;
  assign taps.fz    = c_fz;

  hmbs_blend u_blend (
    .clk   (clk),
    .rst   (rst),
    .taps  (taps),
    .ready (blend_ready),
    .result(result)
  );

endmodule

// ===== rtl/hmbs_checker.sv =====
module hmbs_checker
  import hmbs_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_ready,
  input logic [HEIGHT_W-1:0] result_height
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word present right after reset");

  // height stays within 0..100 world units
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_height <= HEIGHT_MAX))
    else $error("height beyond full scale");

  // a stalled word is not dropped
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result word dropped while stalled");

  // a stalled word does not change
  a_hold_height: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_height))
    else $error("result word changed while stalled");

endmodule

bind heightmap_bilinear_sampler_unit hmbs_checker u_hmbs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_height(result.height)
);

// ===== bench/height_checker.sv =====
`timescale 1ns / 1ps

module height_checker
  import hmbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  hmbs_in_if.monitor  item,
  hmbs_out_if.monitor result,
  hmbs_cfg_if.monitor cfg,
  output int          mismatches,
  output int          pending
);

  localparam int REPORT_LIMIT = 10;

  logic [SAMPLE_W-1:0] map_copy [STORE_DEPTH];
  logic [SIZE_W-1:0]   width_reg;
  logic [SIZE_W-1:0]   height_reg;
  logic [HEIGHT_W-1:0] heights_due [$];
  logic [HEIGHT_W-1:0] due_height;
  int                  error_total;

  // usable map size once degenerate register values are folded in
  function automatic int usable_size(input logic [SIZE_W-1:0] r, input int limit);
    if (r == '0) return 1;
    if (int'(r) > limit) return limit;
    return int'(r);
  endfunction

  // integer part, clamped next index and fraction of an 8.8 coordinate
  function automatic void coord_parts(input logic [QUERY_W-1:0] q, input int last,
                                      output int lo, output int hi, output int frac);
    lo   = int'(q[QUERY_W-1:FRAC_W]);
    frac = int'(q[FRAC_W-1:0]);
    if (lo > last) begin
      lo   = last;
      frac = 0;
    end
    hi = (lo + 1 > last) ? last : lo + 1;
  endfunction

  function automatic longint unsigned sample_at(input int col, input int row, input int stride);
    return longint'(map_copy[row * stride + col]);
  endfunction

  // bilinear blend of the four corners, scaled by 100/255 and truncated
  function automatic logic [HEIGHT_W-1:0] blend_height(input logic [QUERY_W-1:0] qx,
                                                       input logic [QUERY_W-1:0] qz);
    int w, h, x0, x1, z0, z1, fx, fz;
    longint unsigned col_lo, col_hi, mix;
    w = usable_size(width_reg, MAX_WIDTH);
    h = usable_size(height_reg, MAX_HEIGHT);
    coord_parts(qx, w - 1, x0, x1, fx);
    coord_parts(qz, h - 1, z0, z1, fz);
    col_lo = sample_at(x0, z0, w) * (256 - fz) + sample_at(x0, z1, w) * fz;
    col_hi = sample_at(x1, z0, w) * (256 - fz) + sample_at(x1, z1, w) * fz;
    mix    = col_lo * (256 - fx) + col_hi * fx;
    return HEIGHT_W'((mix * 100) / (255 * 256));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      heights_due.delete();
      width_reg   = SIZE_W'(MAX_WIDTH);
      height_reg  = SIZE_W'(MAX_HEIGHT);
      error_total = 0;
    end else begin
      // register writes, unknown indexes fall through
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_MAP_WIDTH) begin
          width_reg = cfg.data;
        end else if (cfg.index == REG_MAP_HEIGHT) begin
          height_reg = cfg.data;
        end
      end
      // load words update the map copy, query words queue a height
      if (item.valid && item.ready) begin
        if (item.mode == MODE_LOAD) begin
          map_copy[item.sample_index] = item.sample_value;
        end else begin
          heights_due.push_back(blend_height(item.query_x, item.query_z));
        end
      end
      // result words against the oldest queued height
      if (result.valid && result.ready) begin
        if (heights_due.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT) begin
            $display("unexpected height word %0d at %0t", result.height, $realtime);
          end
        end else begin
          due_height = heights_due.pop_front();
          if (result.height !== due_height) begin
            error_total++;
            if (error_total <= REPORT_LIMIT) begin
              $display("height mismatch: expected %0d, got %0d at %0t",
                       due_height, result.height, $realtime);
            end
          end
        end
      end
    end
    mismatches <= error_total;
    pending    <= heights_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import hmbs_pkg::*;

  localparam int PHASES          = 8;
  localparam int SPARE_PHASE     = 4;
  localparam int WORDS_PER_PHASE = 24;
  localparam int PIPE_SLACK      = 16;
  localparam int TAIL_CYCLES     = 20;
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 5000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_style_e;

  logic clk;
  logic rst;
  logic hold_req;
  int   mismatch_count;
  int   pending_heights;
  int   quiet_cycles = 0;
  int   burst_left;
  int   cur_w;
  int   cur_h;
  bit   loaded [STORE_DEPTH];

  hmbs_in_if  item_ch ();
  hmbs_out_if result_ch ();
  hmbs_cfg_if cfg_ch ();

  heightmap_bilinear_sampler_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  height_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatch_count),
    .pending    (pending_heights)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int live_size(input int r, input int limit);
    if (r == 0) return 1;
    return (r > limit) ? limit : r;
  endfunction

  // row or column pair that a query touches, edge clamped
  function automatic void axis_pair(input logic [QUERY_W-1:0] q, input int last,
                                    output int lo, output int hi);
    lo = int'(q[QUERY_W-1:FRAC_W]);
    if (lo > last) lo = last;
    hi = (lo + 1 > last) ? last : lo + 1;
  endfunction

  // one input word, with bursts and random gaps between them
  task automatic send_word(input logic m, input logic [INDEX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] val,
                           input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qz);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? 96 : $urandom_range(1, 16);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= m;
    item_ch.sample_index <= idx;
    item_ch.sample_value <= val;
    item_ch.query_x      <= qx;
    item_ch.query_z      <= qz;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic load_sample(input logic [INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    loaded[idx] = 1'b1;
    send_word(MODE_LOAD, idx, val, QUERY_W'($urandom), QUERY_W'($urandom));
  endtask

  task automatic cover_entry(input int addr);
    if (!loaded[addr]) load_sample(INDEX_W'(addr), SAMPLE_W'($urandom));
  endtask

  // query, preceded by loads of any corner not yet written
  task automatic ask_height(input logic [QUERY_W-1:0] qx, input logic [QUERY_W-1:0] qz);
    int w, h, x0, x1, z0, z1;
    w = live_size(cur_w, MAX_WIDTH);
    h = live_size(cur_h, MAX_HEIGHT);
    axis_pair(qx, w - 1, x0, x1);
    axis_pair(qz, h - 1, z0, z1);
    cover_entry(z0 * w + x0);
    cover_entry(z0 * w + x1);
    cover_entry(z1 * w + x0);
    cover_entry(z1 * w + x1);
    send_word(MODE_QUERY, INDEX_W'($urandom), SAMPLE_W'($urandom), qx, qz);
  endtask

  task automatic random_word();
    int pick, w, h;
    logic [QUERY_W-1:0] qx, qz;
    pick = $urandom_range(0, 99);
    w = live_size(cur_w, MAX_WIDTH);
    h = live_size(cur_h, MAX_HEIGHT);
    if (pick < 25) begin
      load_sample(INDEX_W'($urandom), SAMPLE_W'($urandom));
    end else begin
      if (pick < 75) begin
        qx = QUERY_W'($urandom_range(0, w * 256 - 1));
        qz = QUERY_W'($urandom_range(0, h * 256 - 1));
      end else if (pick < 88) begin
        // on or just past the last column and row
        qx = {COORD_W'(w - 1 + $urandom_range(0, 2)), FRAC_W'($urandom)};
        qz = {COORD_W'(h - 1 + $urandom_range(0, 2)), FRAC_W'($urandom)};
      end else begin
        qx = QUERY_W'($urandom);
        qz = QUERY_W'($urandom);
      end
      ask_height(qx, qz);
    end
  endtask

  // register write; valid is left high for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // stop offering and let every queued height and in-flight load drain
  task automatic settle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_heights != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic directed_words();
    load_sample(16'h0000, 8'hFF);
    load_sample(16'hFFFF, 8'hFF);
    ask_height(16'h0000, 16'h0000);
    ask_height(16'hFFFF, 16'hFFFF);
    load_sample(16'h0001, 8'h00);
    load_sample(16'h0100, 8'h00);
    load_sample(16'h0101, 8'h00);
    // largest fractions against a bright origin
    ask_height(16'h00FF, 16'h00FF);
    ask_height(16'h0080, 16'h0000);
    // last column or row with a fraction, next neighbour clamps
    ask_height(16'hFF80, 16'h1040);
    ask_height(16'h2040, 16'hFFC0);
    ask_height(16'hFF00, 16'h0000);
    ask_height(16'h0000, 16'hFFFF);
    ask_height(16'h55AA, 16'hAA55);
  endtask

  // receiver: stall patterns, plus one long hold-off on request
  initial begin : drain_side
    rx_style_e style;
    int        span_len;
    bit        held;
    held = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        style    = rx_style_e'($urandom_range(0, 2));
        span_len = $urandom_range(8, 64);
        repeat (span_len) begin
          case (style)
            RX_OPEN: begin
              result_ch.ready <= 1'b1;
            end
            RX_RANDOM: begin
              result_ch.ready <= 1'($urandom_range(0, 1));
            end
            RX_SPARSE: begin
              result_ch.ready <= ($urandom_range(0, 5) != 0);
            end
            default: begin
              result_ch.ready <= 1'b1;
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // cycles with no word moving on any channel
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("heightmap_bilinear_sampler_unit test failed");
    $finish;
  end

  initial begin : stimulus
    int pw, ph;
    rst                  <= 1'b1;
    hold_req             <= 1'b0;
    item_ch.valid        <= 1'b0;
    item_ch.mode         <= MODE_LOAD;
    item_ch.sample_index <= '0;
    item_ch.sample_value <= '0;
    item_ch.query_x      <= '0;
    item_ch.query_z      <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_MAP_WIDTH;
    cfg_ch.data          <= '0;
    burst_left = 0;
    cur_w      = MAX_WIDTH;
    cur_h      = MAX_HEIGHT;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      settle();
      // map shapes, degenerate and oversized ones among them
      case (p)
        0: begin pw = 256; ph = 256; end
        1: begin pw = 0;   ph = 0;   end
        2: begin pw = 1;   ph = 511; end
        3: begin pw = 511; ph = 1;   end
        4: begin pw = 7;   ph = 5;   end
        5: begin pw = 300; ph = 3;   end
        6: begin pw = 3;   ph = 256; end
        default: begin pw = 256; ph = 256; end
      endcase
      write_reg(REG_MAP_WIDTH, SIZE_W'(pw));
      write_reg(REG_MAP_HEIGHT, SIZE_W'(ph));
      if (p == SPARE_PHASE) write_reg(REG_SPARE, SIZE_W'($urandom));
      cfg_ch.valid <= 1'b0;
      cur_w = pw;
      cur_h = ph;
      if (p == 0) directed_words();
      if (p == SPARE_PHASE) begin
        // a coordinate past the last column saturates; one on the last row clamps its neighbour
        ask_height(16'h0780, 16'h0480);
        ask_height(16'hFFFF, 16'h0000);
      end
      if (p == PHASES - 1) hold_req <= 1'b1;
      repeat (WORDS_PER_PHASE) random_word();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_heights == 0) begin
      $display("heightmap_bilinear_sampler_unit test passed");
    end else begin
      $display("heightmap_bilinear_sampler_unit test failed");
    end
    $finish;
  end

endmodule
